// File: rtl/stt_pkg.sv
`default_nettype none
package stt_pkg;

   localparam int LEXEME_MAX        = 32;
   localparam int NUMBER_MAX_DIGITS = 18;
   localparam int KEYWORD_COUNT     = 28;
   localparam int ADDR_W            = $clog2(LEXEME_MAX);

   localparam logic [3:0] KIND_IDENT   = 4'd0;
   localparam logic [3:0] KIND_KEYWORD = 4'd1;
   localparam logic [3:0] KIND_SIGN    = 4'd2;
   localparam logic [3:0] KIND_INT     = 4'd3;
   localparam logic [3:0] KIND_REAL    = 4'd4;
   localparam logic [3:0] KIND_STRING  = 4'd5;
   localparam logic [3:0] KIND_EOL     = 4'd6;
   localparam logic [3:0] KIND_EOF     = 4'd7;
   localparam logic [3:0] KIND_ERROR   = 4'd8;

   localparam logic [4:0] SG_PLUS   = 5'd0;
   localparam logic [4:0] SG_MINUS  = 5'd1;
   localparam logic [4:0] SG_STAR   = 5'd2;
   localparam logic [4:0] SG_SLASH  = 5'd3;
   localparam logic [4:0] SG_ASSIGN = 5'd4;
   localparam logic [4:0] SG_EQ     = 5'd5;
   localparam logic [4:0] SG_NOT    = 5'd6;
   localparam logic [4:0] SG_AMP    = 5'd7;
   localparam logic [4:0] SG_OR     = 5'd8;
   localparam logic [4:0] SG_LT     = 5'd9;
   localparam logic [4:0] SG_GT     = 5'd10;
   localparam logic [4:0] SG_LE     = 5'd11;
   localparam logic [4:0] SG_GE     = 5'd12;
   localparam logic [4:0] SG_NE     = 5'd13;
   localparam logic [4:0] SG_AND    = 5'd14;
   localparam logic [4:0] SG_LPAR   = 5'd15;
   localparam logic [4:0] SG_RPAR   = 5'd16;
   localparam logic [4:0] SG_LBRACE = 5'd17;
   localparam logic [4:0] SG_RBRACE = 5'd18;
   localparam logic [4:0] SG_LBRACK = 5'd19;
   localparam logic [4:0] SG_RBRACK = 5'd20;
   localparam logic [4:0] SG_COMMA  = 5'd21;

   localparam logic [1:0] ERR_INVALID  = 2'd0;
   localparam logic [1:0] ERR_BAR      = 2'd1;
   localparam logic [1:0] ERR_UNTERM   = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG = 2'd3;

   localparam logic [30:0] INT_SAT  = 31'h7fffffff;
   localparam logic [23:0] LINE_MAX = 24'hffffff;

   localparam logic [63:0] KW_TEXT [0:27] = '{
      "const   ", "pr      ", "init    ", "endp    ", "char    ", "int     ",
      "real    ", "bool    ", "do      ", "while   ", "endw    ", "var     ",
      "from    ", "to      ", "dt      ", "by      ", "if      ", "endv    ",
      "elif    ", "else    ", "endi    ", "getout  ", "getint  ", "getchar ",
      "getreal ", "putint  ", "putchar ", "putreal "
   };
   localparam logic [5:0] KW_LEN [0:27] = '{
      6'd5, 6'd2, 6'd4, 6'd4, 6'd4, 6'd3, 6'd4, 6'd4, 6'd2, 6'd5, 6'd4, 6'd3,
      6'd4, 6'd2, 6'd2, 6'd2, 6'd2, 6'd4, 6'd4, 6'd4, 6'd4, 6'd6, 6'd6, 6'd7,
      6'd7, 6'd6, 6'd7, 6'd7
   };

   typedef struct packed {
      logic [3:0]  kind;
      logic [4:0]  sign;
      logic [4:0]  kw;
      logic [30:0] ival;
      logic [59:0] mant;
      logic [4:0]  frac;
      logic [7:0]  lch;
      logic [5:0]  llen;
      logic [23:0] line;
      logic [1:0]  err;
      logic        last;
   } res_type;

endpackage
`default_nettype wire

// File: rtl/stt_lex_ram.sv
`default_nettype none
module stt_lex_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/source_text_tokenizer.sv
// an accepted byte is latched and then scanned; a single result is registered from the scan state
// req_stall holds new requests until the byte is done; a byte that ends a token is scanned again
// identifier and string runs give one result per lexeme byte, read from the lexeme memory
// reset: synchronous, active high; scanner idle, counters cleared, line counter set to one
// lexeme memory contents are not cleared; only bytes of the current lexeme are read
`default_nettype none
module source_text_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_end_of_file,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [3:0]  rsp_token_kind,
   output      logic [4:0]  rsp_sign_code,
   output      logic [4:0]  rsp_keyword_index,
   output      logic [30:0] rsp_int_value,
   output      logic [59:0] rsp_real_mantissa,
   output      logic [4:0]  rsp_fraction_digits,
   output      logic [7:0]  rsp_lexeme_char,
   output      logic [5:0]  rsp_lexeme_length,
   output      logic [23:0] rsp_line_number,
   output      logic [1:0]  rsp_error_code,
   output      logic        rsp_last
);
   import stt_pkg::*;

   typedef enum logic [1:0] {C_IDLE, C_PROC, C_RD, C_WR} ctl_type;
   typedef enum logic [3:0] {
      S_IDLE, S_IDENT, S_SLASH, S_EQ, S_INT, S_REAL, S_LT, S_GT, S_BANG,
      S_AMP, S_BAR, S_COMMENT, S_STRING, S_IDSKIP, S_STRSKIP, S_NUMSKIP
   } scan_type;

   ctl_type  ctl_ff, ctl_in;
   scan_type scan_ff, scan_in;
   logic [7:0]  byte_ff;
   logic        eof_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic [59:0] acc_ff, acc_in;
   logic [4:0]  dig_ff, dig_in;
   logic [4:0]  frac_ff, frac_in;
   logic [23:0] line_ff, line_in;
   logic [KEYWORD_COUNT-1:0] mask_ff, mask_in;
   logic [5:0]  idx_ff;
   logic        redo_ff;
   logic [3:0]  run_kind_ff;
   logic        rsp_valid_ff;
   res_type     out_ff;

   res_type     res;
   res_type     run_res;
   logic        emit, run, redo;
   logic [3:0]  run_kind;
   logic        wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]  rd_data;
   logic        out_free, act, wr_last;
   logic        alpha, digit, nl;
   logic        kw_hit;
   logic [4:0]  kw_idx;
   logic [59:0] acc_next;

   stt_lex_ram #(.DEPTH(LEXEME_MAX), .WIDTH(8)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (byte_ff),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign act       = (ctl_ff == C_PROC) && out_free;
   assign wr_last   = (idx_ff + 6'd1) == cnt_ff;
   assign req_stall = (ctl_ff != C_IDLE);

   assign alpha = !eof_ff && ((byte_ff >= "a" && byte_ff <= "z") ||
                  (byte_ff >= "A" && byte_ff <= "Z") || byte_ff == "_");
   assign digit = !eof_ff && byte_ff >= "0" && byte_ff <= "9";
   assign nl    = !eof_ff && byte_ff == 8'h0a;
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + 60'(byte_ff - "0");

   always_comb begin
      kw_hit = 1'b0;
      kw_idx = '0;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k] && KW_LEN[k] == cnt_ff) begin
            kw_hit = 1'b1;
            kw_idx = 5'(k);
         end
      end
   end

   always_comb begin
      scan_in  = scan_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      dig_in   = dig_ff;
      frac_in  = frac_ff;
      line_in  = line_ff;
      mask_in  = mask_ff;
      emit     = 1'b0;
      run      = 1'b0;
      redo     = 1'b0;
      run_kind = KIND_IDENT;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff[ADDR_W-1:0];
      res      = '0;
      res.line = line_ff;
      res.last = 1'b1;
      case (scan_ff)
         S_IDENT: begin
            if (alpha || digit) begin
               if (cnt_ff >= 6'(LEXEME_MAX)) begin
                  emit = 1'b1; res.kind = KIND_ERROR; res.err = ERR_TOO_LONG;
                  scan_in = S_IDSKIP;
               end else begin
                  wr_en  = act;
                  cnt_in = cnt_ff + 6'd1;
                  for (int k = 0; k < KEYWORD_COUNT; k++) begin
                     mask_in[k] = mask_ff[k] && cnt_ff < 6'd8 &&
                        KW_TEXT[k][(7 - cnt_ff[2:0]) * 8 +: 8] == byte_ff;
                  end
               end
            end else begin
               if (kw_hit) begin
                  emit = 1'b1; res.kind = KIND_KEYWORD; res.kw = kw_idx;
               end else begin
                  run = 1'b1; run_kind = KIND_IDENT;
               end
               scan_in = S_IDLE; redo = 1'b1;
            end
         end
         S_IDSKIP: begin
            if (!(alpha || digit)) begin
               scan_in = S_IDLE; redo = 1'b1;
            end
         end
         S_SLASH: begin
            if (!eof_ff && byte_ff == "/") begin
               scan_in = S_COMMENT;
            end else begin
               emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_SLASH;
               scan_in = S_IDLE; redo = 1'b1;
            end
         end
         S_COMMENT: begin
            if (nl || eof_ff) begin
               scan_in = S_IDLE; redo = 1'b1;
            end
         end
         S_EQ, S_LT, S_GT, S_BANG, S_AMP: begin
            emit = 1'b1; res.kind = KIND_SIGN; scan_in = S_IDLE;
            if (scan_ff == S_AMP) begin
               redo = !(!eof_ff && byte_ff == "&");
               res.sign = redo ? SG_AMP : SG_AND;
            end else begin
               redo = !(!eof_ff && byte_ff == "=");
               case (scan_ff)
                  S_EQ:    res.sign = redo ? SG_ASSIGN : SG_EQ;
                  S_LT:    res.sign = redo ? SG_LT : SG_LE;
                  S_GT:    res.sign = redo ? SG_GT : SG_GE;
                  default: res.sign = redo ? SG_NOT : SG_NE;
               endcase
            end
         end
         S_BAR: begin
            emit = 1'b1; scan_in = S_IDLE;
            if (!eof_ff && byte_ff == "|") begin
               res.kind = KIND_SIGN; res.sign = SG_OR;
            end else begin
               res.kind = KIND_ERROR; res.err = ERR_BAR; redo = 1'b1;
            end
         end
         S_INT, S_REAL: begin
            if (digit) begin
               if (dig_ff >= 5'(NUMBER_MAX_DIGITS)) begin
                  emit = 1'b1; res.kind = KIND_ERROR; res.err = ERR_TOO_LONG;
                  scan_in = S_NUMSKIP;
               end else begin
                  acc_in = acc_next;
                  dig_in = dig_ff + 5'd1;
                  if (scan_ff == S_REAL) frac_in = frac_ff + 5'd1;
               end
            end else if (!eof_ff && byte_ff == "." && scan_ff == S_INT) begin
               scan_in = S_REAL;
            end else begin
               emit = 1'b1;
               if (scan_ff == S_REAL) begin
                  res.kind = KIND_REAL; res.mant = acc_ff; res.frac = frac_ff;
               end else begin
                  res.kind = KIND_INT;
                  res.ival = (acc_ff > 60'(INT_SAT)) ? INT_SAT : acc_ff[30:0];
               end
               scan_in = S_IDLE; redo = 1'b1;
            end
         end
         S_NUMSKIP: begin
            if (!(digit || (!eof_ff && byte_ff == "."))) begin
               scan_in = S_IDLE; redo = 1'b1;
            end
         end
         S_STRING: begin
            if (!eof_ff && byte_ff == "\"") begin
               if (cnt_ff == 6'd0) begin
                  emit = 1'b1; res.kind = KIND_STRING;
               end else begin
                  run = 1'b1; run_kind = KIND_STRING;
               end
               scan_in = S_IDLE;
            end else if (nl || eof_ff) begin
               emit = 1'b1; res.kind = KIND_ERROR; res.err = ERR_UNTERM;
               scan_in = S_IDLE; redo = 1'b1;
            end else if (cnt_ff >= 6'(LEXEME_MAX)) begin
               emit = 1'b1; res.kind = KIND_ERROR; res.err = ERR_TOO_LONG;
               scan_in = S_STRSKIP;
            end else begin
               wr_en = act; cnt_in = cnt_ff + 6'd1;
            end
         end
         S_STRSKIP: begin
            if (!eof_ff && byte_ff == "\"") begin
               scan_in = S_IDLE;
            end else if (nl || eof_ff) begin
               scan_in = S_IDLE; redo = 1'b1;
            end
         end
         default: begin
            scan_in = S_IDLE;
            if (eof_ff) begin
               emit = 1'b1; res.kind = KIND_EOF;
            end else if (alpha) begin
               wr_en = act; wr_addr = '0; cnt_in = 6'd1; scan_in = S_IDENT;
               for (int k = 0; k < KEYWORD_COUNT; k++) begin
                  mask_in[k] = KW_TEXT[k][63:56] == byte_ff;
               end
            end else if (byte_ff >= "1" && byte_ff <= "9") begin
               acc_in = 60'(byte_ff - "0"); dig_in = 5'd1; frac_in = 5'd0;
               scan_in = S_INT;
            end else begin
               case (byte_ff)
                  " ", 8'h09: ;
                  "+": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_PLUS; end
                  "-": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_MINUS; end
                  "*": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_STAR; end
                  "(": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_LPAR; end
                  ")": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_RPAR; end
                  "{": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_LBRACE; end
                  "}": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_RBRACE; end
                  "[": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_LBRACK; end
                  "]": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_RBRACK; end
                  ",": begin emit = 1'b1; res.kind = KIND_SIGN; res.sign = SG_COMMA; end
                  "/": scan_in = S_SLASH;
                  "=": scan_in = S_EQ;
                  "<": scan_in = S_LT;
                  ">": scan_in = S_GT;
                  "!": scan_in = S_BANG;
                  "&": scan_in = S_AMP;
                  "|": scan_in = S_BAR;
                  "\"": begin cnt_in = 6'd0; scan_in = S_STRING; end
                  8'h0a: begin
                     if (line_ff < LINE_MAX) line_in = line_ff + 24'd1;
                     emit = 1'b1; res.kind = KIND_EOL; res.line = line_in;
                  end
                  default: begin emit = 1'b1; res.kind = KIND_ERROR; res.err = ERR_INVALID; end
               endcase
            end
         end
      endcase
   end

   always_comb begin
      run_res      = '0;
      run_res.kind = run_kind_ff;
      run_res.lch  = rd_data;
      run_res.llen = cnt_ff;
      run_res.line = line_ff;
      run_res.last = wr_last;
   end

   always_comb begin
      ctl_in = ctl_ff;
      case (ctl_ff)
         C_IDLE:  if (req_valid) ctl_in = C_PROC;
         C_PROC:  if (out_free) ctl_in = run ? C_RD : (redo ? C_PROC : C_IDLE);
         C_RD:    ctl_in = C_WR;
         C_WR:    if (out_free) ctl_in = wr_last ? (redo_ff ? C_PROC : C_IDLE) : C_RD;
         default: ctl_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= C_IDLE;
         scan_ff      <= S_IDLE;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         dig_ff       <= '0;
         frac_ff      <= '0;
         line_ff      <= 24'd1;
         mask_ff      <= '0;
         idx_ff       <= '0;
         redo_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
         if ((act && emit) || (ctl_ff == C_WR && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl_ff == C_IDLE && req_valid) begin
            byte_ff <= req_char_byte;
            eof_ff  <= req_end_of_file;
         end
         if (act) begin
            scan_ff <= scan_in;
            cnt_ff  <= cnt_in;
            acc_ff  <= acc_in;
            dig_ff  <= dig_in;
            frac_ff <= frac_in;
            line_ff <= line_in;
            mask_ff <= mask_in;
            if (emit) begin
               out_ff <= res;
            end
            if (run) begin
               idx_ff      <= '0;
               redo_ff     <= redo;
               run_kind_ff <= run_kind;
            end
         end
         if (ctl_ff == C_WR && out_free) begin
            out_ff <= run_res;
            idx_ff <= idx_ff + 6'd1;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_token_kind      = out_ff.kind;
   assign rsp_sign_code       = out_ff.sign;
   assign rsp_keyword_index   = out_ff.kw;
   assign rsp_int_value       = out_ff.ival;
   assign rsp_real_mantissa   = out_ff.mant;
   assign rsp_fraction_digits = out_ff.frac;
   assign rsp_lexeme_char     = out_ff.lch;
   assign rsp_lexeme_length   = out_ff.llen;
   assign rsp_line_number     = out_ff.line;
   assign rsp_error_code      = out_ff.err;
   assign rsp_last            = out_ff.last;

endmodule
`default_nettype wire

// File: rtl/stt_checker.sv
`default_nettype none
module stt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_token_kind,
   input wire logic [5:0]  rsp_lexeme_length,
   input wire logic [23:0] rsp_line_number,
   input wire logic        rsp_last
);
   import stt_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_IDENT && rsp_token_kind != KIND_STRING
      |-> rsp_last && rsp_lexeme_length == 6'd0)
      else $error("single token with run fields");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != 24'd0)
      else $error("line number zero");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_token_kind    (rsp_token_kind),
   .rsp_lexeme_length (rsp_lexeme_length),
   .rsp_line_number   (rsp_line_number),
   .rsp_last          (rsp_last)
);
`default_nettype wire
